// ===== rtl/skr_pkg.sv =====
`timescale 1ns / 1ps
// skr_pkg: shared types and constants of the shard key router.
// No dependencies; used by shard_key_router, its checker and the bench.
package skr_pkg;

   // request opcodes
   localparam logic [1:0] OP_WRITE_RANGE = 2'd0;
   localparam logic [1:0] OP_INT_KEY     = 2'd1;
   localparam logic [1:0] OP_STR_BYTE    = 2'd2;

   // csr register indexes
   localparam logic CSR_USE_HASH    = 1'b0;
   localparam logic CSR_SHARD_TOTAL = 1'b1;

   localparam logic [63:0] HASH_SEED  = 64'd5381;
   localparam int          HASH_SHIFT = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  entry_index;
      logic [63:0] range_low;
      logic [63:0] range_high;
      logic [63:0] key_value;
      logic [7:0]  text_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] shard_slot;
      logic       no_shard;
      logic       fell_back;
   } rsp_type;

endpackage

// ===== rtl/shard_key_router.sv =====
`timescale 1ns / 1ps
// shard_key_router: routes integer or string keys to a shard slot.
// Depends on skr_pkg.
//
// Range writes and non-final string bytes are taken while idle and leave
// the block idle. A lookup (integer key, or the final string byte) is
// accepted, then in hash mode runs through the bit-serial modulo unit, in
// range mode scans the slots (table read, then compare) until a hit or the
// last of count slots, then loads the response register once that is free.
// A zero shard count goes straight to a no_shard response. A new word is
// accepted while the previous response still waits.
// Range slots must be written before a lookup can reach them.
module shard_key_router #(
   parameter int MAX_SHARDS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  skr_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output skr_pkg::rsp_type rsp_word,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [4:0]       csr_wdata
);
   import skr_pkg::*;

   localparam int IdxW  = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int ScanW = (IdxW > 5) ? IdxW : 5;

   state_type state_ff, state_in;

   logic        use_hash_ff;
   logic [4:0]  total_ff;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] key_ff;
   logic [4:0]  rem_ff;
   logic [5:0]  bit_cnt_ff;
   logic [ScanW-1:0] scan_ff;
   logic [63:0] rd_lo_ff, rd_hi_ff;
   rsp_type     res_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [63:0] lo_mem [MAX_SHARDS];
   logic [63:0] hi_mem [MAX_SHARDS];

   logic [4:0]  count;
   logic        lookup_req;
   logic        accept;
   logic        rsp_load;
   logic [5:0]  trial;
   logic        trial_ge;
   logic [4:0]  rem_nx;
   logic        hit;
   logic        scan_last;
   logic [63:0] byte_sx;
   logic [IdxW-1:0] wr_addr;
   logic        wr_ok;

   // count saturates at the table depth
   assign count = (32'(total_ff) > MAX_SHARDS) ? 5'(MAX_SHARDS) : total_ff;

   assign byte_sx = {{56{req_word.text_byte[7]}}, req_word.text_byte};
   assign hash_in = (hash_ff << HASH_SHIFT) + hash_ff + byte_sx;

   assign lookup_req = (req_word.op == OP_INT_KEY) ||
                       ((req_word.op == OP_STR_BYTE) && req_word.last_byte);
   assign accept     = req_valid && req_ready;

   // restoring modulo step, one key bit per cycle
   assign trial    = {rem_ff, key_ff[63]};
   assign trial_ge = trial >= {1'b0, count};
   assign rem_nx   = trial_ge ? 5'(trial - {1'b0, count}) : 5'(trial);

   assign hit       = (key_ff >= rd_lo_ff) && (key_ff < rd_hi_ff);
   assign scan_last = (scan_ff + ScanW'(1)) == ScanW'(count);

   assign wr_addr = IdxW'(req_word.entry_index);
   assign wr_ok   = 32'(req_word.entry_index) < MAX_SHARDS;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && lookup_req) begin
               if (count == 5'd0) begin
                  state_in = ST_DONE;
               end else if (use_hash_ff) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DIV: begin
            if (bit_cnt_ff == 6'd63) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            if (hit || scan_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DONE: rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         use_hash_ff  <= 1'b0;
         total_ff     <= 5'd0;
         hash_ff      <= HASH_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_USE_HASH:    use_hash_ff <= csr_wdata[0];
               CSR_SHARD_TOTAL: total_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && (req_word.op == OP_STR_BYTE)) begin
            hash_ff <= req_word.last_byte ? HASH_SEED : hash_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // range table
   always_ff @(posedge clock) begin
      if (accept && (req_word.op == OP_WRITE_RANGE) && wr_ok) begin
         lo_mem[wr_addr] <= req_word.range_low;
         hi_mem[wr_addr] <= req_word.range_high;
      end
      rd_lo_ff <= lo_mem[scan_ff[IdxW-1:0]];
      rd_hi_ff <= hi_mem[scan_ff[IdxW-1:0]];
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            key_ff     <= (req_word.op == OP_INT_KEY) ? req_word.key_value : hash_in;
            rem_ff     <= 5'd0;
            bit_cnt_ff <= 6'd0;
            scan_ff    <= '0;
            res_ff     <= '{shard_slot: 4'd0, no_shard: 1'b1, fell_back: 1'b0};
         end
         ST_DIV: begin
            key_ff     <= {key_ff[62:0], 1'b0};
            rem_ff     <= rem_nx;
            bit_cnt_ff <= bit_cnt_ff + 6'd1;
            res_ff     <= '{shard_slot: rem_nx[3:0], no_shard: 1'b0, fell_back: 1'b0};
         end
         ST_CMP: begin
            if (hit) begin
               res_ff <= '{shard_slot: scan_ff[3:0], no_shard: 1'b0, fell_back: 1'b0};
            end else begin
               res_ff <= '{shard_slot: 4'd0, no_shard: 1'b0, fell_back: 1'b1};
            end
            scan_ff <= scan_ff + ScanW'(1);
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/skr_checker.sv =====
`timescale 1ns / 1ps
// skr_checker: port-level assertions for shard_key_router, bound to it below.
// Depends on skr_pkg.
module skr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input skr_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input skr_pkg::rsp_type rsp_word
);
   import skr_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_no_shard: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.no_shard |-> rsp_word.shard_slot == 4'd0 && !rsp_word.fell_back)
      else $error("no_shard word carries a slot or fallback");

   // an accepted integer-key lookup leaves the block busy in the cycle after
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.op == OP_INT_KEY |=> !req_ready)
      else $error("accepted a word right after a lookup");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind shard_key_router skr_checker u_skr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ===== test/shard_key_router_tb.sv =====
`timescale 1ns / 1ps
// shard_key_router_tb: self-checking bench for the shard key router; an own
// route predictor, a queue-fed driver and a response monitor.
// Depends on skr_pkg and shard_key_router.
module shard_key_router_tb;
   import skr_pkg::*;

   localparam int          CLK_HALF      = 2;
   localparam int          SLOTS         = 16;
   localparam logic [1:0]  OP_NONE       = 2'd3;   // unused code, block drops it
   localparam int          SETTLE_CYCLES = 100;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          PRINT_LIMIT   = 50;
   localparam logic [63:0] KEY_MAX       = '1;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_word  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_word;
   logic       csr_we    = 1'b0;
   logic       csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   // predictor state
   logic [63:0] route_low  [SLOTS];
   logic [63:0] route_high [SLOTS];
   logic [63:0] text_hash   = HASH_SEED;
   logic        hash_mode   = 1'b0;
   logic [4:0]  slot_total  = '0;

   // ranges as queued, used to aim keys at boundaries
   logic [63:0] plan_low  [SLOTS];
   logic [63:0] plan_high [SLOTS];

   req_type     send_queue[$];
   rsp_type     expected_routes[$];
   int unsigned error_count   = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned queued_items  = 0;
   bit          hold_request  = 1'b0;
   logic        rsp_hold      = 1'b0;

   shard_key_router #(
      .MAX_SHARDS(SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic rsp_type route_shard(input logic [63:0] key);
      rsp_type r;
      int      count;
      r = '0;
      count = (slot_total > SLOTS) ? SLOTS : int'(slot_total);
      if (count == 0) begin
         r.no_shard = 1'b1;
      end else if (hash_mode) begin
         r.shard_slot = 4'(key % 64'(count));
      end else begin
         // scan from the top so the lowest matching slot is the one left
         r.fell_back = 1'b1;
         for (int i = count - 1; i >= 0; i--) begin
            if (key >= route_low[i] && key < route_high[i]) begin
               r.shard_slot = 4'(i);
               r.fell_back  = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic void track_word(input req_type w);
      logic [63:0] byte_ext;
      case (w.op)
         OP_WRITE_RANGE: begin
            route_low[w.entry_index]  = w.range_low;
            route_high[w.entry_index] = w.range_high;
         end
         OP_INT_KEY: begin
            expected_routes.push_back(route_shard(w.key_value));
         end
         OP_STR_BYTE: begin
            byte_ext  = {{56{w.text_byte[7]}}, w.text_byte};
            text_hash = (text_hash << HASH_SHIFT) + text_hash + byte_ext;
            if (w.last_byte) begin
               expected_routes.push_back(route_shard(text_hash));
               text_hash = HASH_SEED;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= send_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // checks results first, then predicts from the word taken at this edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_routes.size() == 0) begin
               report_mismatch("result with nothing pending", 1, 0);
            end else begin
               want = expected_routes.pop_front();
               if (rsp_word.shard_slot !== want.shard_slot)
                  report_mismatch("shard_slot", rsp_word.shard_slot, want.shard_slot);
               if (rsp_word.no_shard !== want.no_shard)
                  report_mismatch("no_shard", rsp_word.no_shard, want.no_shard);
               if (rsp_word.fell_back !== want.fell_back)
                  report_mismatch("fell_back", rsp_word.fell_back, want.fell_back);
            end
         end
         if (req_valid && req_ready)
            track_word(req_word);
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : receiver_hold
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type noise_word();
      req_type w;
      w.op          = 2'($urandom);
      w.entry_index = 4'($urandom);
      w.range_low   = {$urandom, $urandom};
      w.range_high  = {$urandom, $urandom};
      w.key_value   = {$urandom, $urandom};
      w.text_byte   = 8'($urandom);
      w.last_byte   = 1'($urandom);
      return w;
   endfunction

   function automatic void queue_range(input logic [3:0] idx, input logic [63:0] lo,
                                       input logic [63:0] hi);
      req_type w;
      w = noise_word();
      w.op          = OP_WRITE_RANGE;
      w.entry_index = idx;
      w.range_low   = lo;
      w.range_high  = hi;
      plan_low[idx]  = lo;
      plan_high[idx] = hi;
      send_queue.push_back(w);
      queued_items++;
   endfunction

   function automatic void queue_random_range(input logic [3:0] idx);
      logic [63:0] lo;
      logic [63:0] hi;
      lo = {$urandom, $urandom};
      case ($urandom_range(9))
         0: hi = lo;
         1: begin
            lo = '0;
            hi = KEY_MAX;
         end
         2: hi = {$urandom, $urandom};
         3: begin
            // wraps past the top: an empty range
            lo = KEY_MAX - 64'($urandom_range(100));
            hi = lo + 64'd200;
         end
         default: hi = lo + 64'($urandom_range(1, 65536));
      endcase
      queue_range(idx, lo, hi);
   endfunction

   function automatic void queue_key(input logic [63:0] key);
      req_type w;
      w = noise_word();
      w.op        = OP_INT_KEY;
      w.key_value = key;
      send_queue.push_back(w);
      queued_items++;
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic last);
      req_type w;
      w = noise_word();
      w.op        = OP_STR_BYTE;
      w.text_byte = b;
      w.last_byte = last;
      send_queue.push_back(w);
      queued_items++;
   endfunction

   function automatic void queue_text(input int unsigned len, input bit terminate);
      for (int unsigned i = 0; i < len; i++)
         queue_byte(8'($urandom), terminate && (i == len - 1));
   endfunction

   function automatic void queue_stray();
      req_type w;
      w = noise_word();
      w.op = OP_NONE;
      send_queue.push_back(w);
   endfunction

   // keys mostly land on or next to a slot boundary
   function automatic logic [63:0] pick_key();
      int unsigned s;
      s = $urandom_range(SLOTS - 1);
      case ($urandom_range(7))
         0: return plan_low[s];
         1: return plan_low[s] - 64'd1;
         2: return plan_high[s];
         3: return plan_high[s] - 64'd1;
         4: return plan_low[s] + 64'($urandom_range(255));
         5: return $urandom_range(1) ? KEY_MAX : 64'($urandom_range(3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void queue_mix(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      goal = queued_items + count;
      while (queued_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 8)
            queue_random_range(4'($urandom_range(SLOTS - 1)));
         else if (pick < 45)
            queue_key(pick_key());
         else if (pick < 94)
            queue_text(($urandom_range(9) < 7) ? $urandom_range(1, 8)
                                                : $urandom_range(9, 24), 1'b1);
         else if (pick < 97)
            queue_text($urandom_range(1, 4), 1'b0);  // runs on into the next key
         else
            queue_stray();
      end
   endfunction

   task automatic write_csr(input logic idx, input logic [4:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_USE_HASH)
         hash_mode = value[0];
      else
         slot_total = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_rules(input logic hash, input logic [4:0] total);
      // upper bits of the mode write are don't-care
      write_csr(CSR_USE_HASH, {4'($urandom_range(15)), hash});
      write_csr(CSR_SHARD_TOTAL, total);
      @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      while (send_queue.size() != 0 || req_valid || expected_routes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic hash, input logic [4:0] total,
                            input int unsigned idle, input int unsigned stall,
                            input int unsigned items, input bit squeeze);
      set_rules(hash, total);
      send_idle_pct = idle;
      stall_pct     = stall;
      if (squeeze)
         hold_request = 1'b1;
      queue_mix(items);
      settle();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // range mode over four slots: overlap, boundaries, miss
      set_rules(1'b0, 5'd4);
      queue_range(4'd0, 64'd100, 64'd200);
      queue_range(4'd1, 64'd150, 64'd300);
      queue_range(4'd2, KEY_MAX - 64'd15, KEY_MAX);
      queue_range(4'd3, 64'd0, 64'd1);
      queue_range(4'd15, 64'd5, 64'd5);
      queue_key(64'd0);
      queue_key(64'd150);
      queue_key(64'd200);
      queue_key(64'd300);
      queue_key(64'd99);
      queue_key(KEY_MAX - 64'd1);
      queue_key(KEY_MAX);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7f, 1'b0);
      queue_byte(8'hff, 1'b1);
      queue_stray();
      settle();

      // zero count: no shard, string still restarts its hash
      set_rules(1'b0, 5'd0);
      queue_key(64'd150);
      queue_byte(8'h61, 1'b1);
      settle();

      // count above the table size saturates
      set_rules(1'b1, 5'd31);
      queue_key(KEY_MAX);
      queue_key(64'd0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h41, 1'b1);
      for (int i = 0; i < SLOTS; i++)
         queue_random_range(4'(i));
      settle();

      run_phase(1'b0, 5'd16, 0, 0, 250, 1'b0);
      run_phase(1'b1, 5'd7, 45, 0, 200, 1'b0);
      run_phase(1'b0, 5'd5, 0, 45, 200, 1'b0);
      run_phase(1'b1, 5'd16, 9, 9, 200, 1'b0);
      run_phase(1'b0, 5'd31, 45, 0, 150, 1'b0);
      run_phase(1'b1, 5'd1, 0, 45, 100, 1'b0);
      run_phase(1'b0, 5'd1, 9, 9, 100, 1'b0);
      run_phase(1'b1, 5'd0, 0, 0, 60, 1'b0);
      run_phase(1'b0, 5'd12, 0, 0, 150, 1'b1);
      run_phase(1'b1, 5'($urandom_range(2, 15)), 9, 9, 150, 1'b0);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/skr_pkg.sv
rtl/shard_key_router.sv
rtl/skr_checker.sv
test/shard_key_router_tb.sv
